FILE: sv/xmcs_pkg.sv
// Package: types, codes and constants for the XMODEM checksum sender.
package xmcs_pkg;

  localparam int unsigned PayloadBytes = 128;
  localparam int unsigned CfgAddrW     = 3;
  localparam int unsigned CfgDataW     = 32;

  localparam logic [7:0] PadReset = 8'h1a;
  localparam logic [7:0] ChSoh    = 8'h01;
  localparam logic [7:0] ChAck    = 8'h06;
  localparam logic [7:0] ChNak    = 8'h15;
  localparam logic [7:0] ChEot    = 8'h04;
  localparam logic [7:0] BlkReset = 8'h01;

  typedef enum logic [1:0] {
    OpLoad  = 2'd0,
    OpEof   = 2'd1,
    OpPull  = 2'd2,
    OpReply = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PhLoad = 3'd0,
    PhSend = 3'd1,
    PhWait = 3'd2,
    PhEotP = 3'd3,
    PhEotW = 3'd4,
    PhDone = 3'd5,
    PhErr  = 3'd6
  } phase_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       frame_end;
    logic       accepted;
    logic       retransmit;
    logic [2:0] phase;
    logic [7:0] block_number;
  } out_req_t;

  // item in flight between the buffer read and the output register
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic       frame_end;
    logic       accepted;
    logic       retransmit;
    logic       use_mem;
    logic       add_ck;
    logic       clr_ck;
    logic       put_ck;
    logic [2:0] phase;
    logic [7:0] block_number;
  } s1_t;

endpackage

FILE: sv/xmcs_buf.sv
// Block buffer: single-port-write, registered-read byte memory.
module xmcs_buf #(
  parameter int unsigned PAYLOAD_BYTES = xmcs_pkg::PayloadBytes
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(PAYLOAD_BYTES)-1:0] waddr_i,
  input  logic [7:0]                       wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(PAYLOAD_BYTES)-1:0] raddr_i,
  output logic [7:0]                       rdata_o
);

  logic [7:0] mem [PAYLOAD_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/xmodem_checksum_sender.sv
// Top level: XMODEM checksum sender with block buffer, frame sequencer and output register.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+-----------------------
//   in       | sink      | in_valid_i / in_ready_o  | in_req_i  (in_req_t)
//   out      | source    | out_valid_o / out_ready_i| out_req_o (out_req_t)
//   apb      | slave     | psel/penable/pready      | pad_byte at offset 0
//
// One request per cycle while the output is not stalled; each result passes through
// the buffer read stage, then the output register. The buffer read latency sets
// the depth. Reset gives phase loading, block number 1, pad byte 0x1a.
// A stalled output holds the read stage; input is taken while the output
// register drains.
module xmodem_checksum_sender #(
  parameter int unsigned PAYLOAD_BYTES = xmcs_pkg::PayloadBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  xmcs_pkg::in_req_t             in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output xmcs_pkg::out_req_t            out_req_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [xmcs_pkg::CfgAddrW-1:0] paddr,
  input  logic [xmcs_pkg::CfgDataW-1:0] pwdata,
  output logic [xmcs_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);

  localparam int unsigned AW    = $clog2(PAYLOAD_BYTES);
  localparam int unsigned FillW = $clog2(PAYLOAD_BYTES + 1);
  localparam int unsigned PosW  = $clog2(PAYLOAD_BYTES + 4);
  localparam logic [FillW-1:0] FillFull = FillW'(PAYLOAD_BYTES);
  localparam logic [PosW-1:0]  PosCk    = PosW'(PAYLOAD_BYTES + 3);

  xmcs_pkg::phase_e   phase_q, phase_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [7:0]         blk_q, blk_d;
  logic               end_q, end_d;
  logic [7:0]         pad_q;
  logic [7:0]         ck_q;

  logic               p1_valid_q;
  xmcs_pkg::s1_t      p1_q, p1_d;
  logic               o_valid_q;
  xmcs_pkg::out_req_t o_q;

  logic               o_adv, p1_adv, accept;
  logic               is_load, is_eof, is_pull, is_reply;
  logic [FillW-1:0]   fill_inc;
  logic [PosW-1:0]    k_full;
  logic               we, re;
  logic [7:0]         rdata;
  logic [7:0]         s1_byte;

  // APB
  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : {{(xmcs_pkg::CfgDataW - 8){1'b0}}, pad_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_q <= xmcs_pkg::PadReset;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      pad_q <= pwdata[7:0];
    end
  end

  // handshake
  assign o_adv      = !o_valid_q || out_ready_i;
  assign p1_adv     = p1_valid_q && o_adv;
  assign in_ready_o = !p1_valid_q || o_adv;
  assign accept     = in_valid_i && in_ready_o;

  assign is_load  = in_req_i.opcode == xmcs_pkg::OpLoad;
  assign is_eof   = in_req_i.opcode == xmcs_pkg::OpEof;
  assign is_pull  = in_req_i.opcode == xmcs_pkg::OpPull;
  assign is_reply = in_req_i.opcode == xmcs_pkg::OpReply;

  assign fill_inc = fill_q + FillW'(1);
  assign k_full   = pos_q - PosW'(3);

  // next state
  always_comb begin
    phase_d = phase_q;
    fill_d  = fill_q;
    pos_d   = pos_q;
    blk_d   = blk_q;
    end_d   = end_q;
    we      = 1'b0;
    unique case (phase_q)
      xmcs_pkg::PhLoad: begin
        if (is_load) begin
          if (fill_q < FillFull) begin
            we     = 1'b1;
            fill_d = fill_inc;
          end
          if (fill_d >= FillFull) begin
            pos_d   = '0;
            phase_d = xmcs_pkg::PhSend;
          end
        end else if (is_eof) begin
          end_d = 1'b1;
          if (fill_q != '0) begin
            pos_d   = '0;
            phase_d = xmcs_pkg::PhSend;
          end else begin
            phase_d = xmcs_pkg::PhEotP;
          end
        end
      end
      xmcs_pkg::PhSend: begin
        if (is_pull) begin
          pos_d = pos_q + PosW'(1);
          if (pos_q >= PosCk) begin
            phase_d = xmcs_pkg::PhWait;
          end
        end
      end
      xmcs_pkg::PhWait: begin
        if (is_reply) begin
          if (in_req_i.data_byte == xmcs_pkg::ChAck) begin
            blk_d   = blk_q + 8'd1;
            fill_d  = '0;
            phase_d = end_q ? xmcs_pkg::PhEotP : xmcs_pkg::PhLoad;
          end else if (in_req_i.data_byte == xmcs_pkg::ChNak) begin
            pos_d   = '0;
            phase_d = xmcs_pkg::PhSend;
          end else begin
            phase_d = xmcs_pkg::PhErr;
          end
        end
      end
      xmcs_pkg::PhEotP: begin
        if (is_pull) begin
          phase_d = xmcs_pkg::PhEotW;
        end
      end
      xmcs_pkg::PhEotW: begin
        if (is_reply) begin
          phase_d = (in_req_i.data_byte == xmcs_pkg::ChAck) ? xmcs_pkg::PhDone
                                                             : xmcs_pkg::PhErr;
        end
      end
      default: begin
      end
    endcase
  end

  // stage-1 item
  always_comb begin
    p1_d              = '0;
    p1_d.phase        = phase_d;
    p1_d.block_number = blk_d;
    re                = 1'b0;
    unique case (phase_q)
      xmcs_pkg::PhLoad: begin
        p1_d.accepted = is_load || is_eof;
      end
      xmcs_pkg::PhSend: begin
        if (is_pull) begin
          p1_d.tx_valid = 1'b1;
          if (pos_q == PosW'(0)) begin
            p1_d.tx_byte = xmcs_pkg::ChSoh;
            p1_d.clr_ck  = 1'b1;
          end else if (pos_q == PosW'(1)) begin
            p1_d.tx_byte = blk_q;
          end else if (pos_q == PosW'(2)) begin
            p1_d.tx_byte = 8'hff - blk_q;
          end else if (pos_q < PosCk) begin
            p1_d.add_ck = 1'b1;
            if (k_full < PosW'(fill_q)) begin
              p1_d.use_mem = 1'b1;
              re           = accept;
            end else begin
              p1_d.tx_byte = pad_q;
            end
          end else begin
            p1_d.put_ck    = 1'b1;
            p1_d.frame_end = 1'b1;
          end
        end
      end
      xmcs_pkg::PhWait: begin
        p1_d.retransmit = is_reply && (in_req_i.data_byte == xmcs_pkg::ChNak);
      end
      xmcs_pkg::PhEotP: begin
        if (is_pull) begin
          p1_d.tx_valid  = 1'b1;
          p1_d.tx_byte   = xmcs_pkg::ChEot;
          p1_d.frame_end = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  xmcs_buf #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (accept && we),
    .waddr_i(fill_q[AW-1:0]),
    .wdata_i(in_req_i.data_byte),
    .re_i   (re),
    .raddr_i(k_full[AW-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= xmcs_pkg::PhLoad;
      fill_q  <= '0;
      pos_q   <= '0;
      blk_q   <= xmcs_pkg::BlkReset;
      end_q   <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      fill_q  <= fill_d;
      pos_q   <= pos_d;
      blk_q   <= blk_d;
      end_q   <= end_d;
    end
  end

  // stage 1: resolve buffer data, keep checksum in request order
  assign s1_byte = p1_q.put_ck  ? ck_q  :
                   p1_q.use_mem ? rdata : p1_q.tx_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      ck_q       <= '0;
      o_valid_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        p1_valid_q <= accept;
      end
      if (p1_adv) begin
        if (p1_q.clr_ck) begin
          ck_q <= '0;
        end else if (p1_q.add_ck) begin
          ck_q <= ck_q + s1_byte;
        end
      end
      if (o_adv) begin
        o_valid_q <= p1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p1_q <= p1_d;
    end
    if (p1_adv) begin
      o_q.tx_byte      <= s1_byte;
      o_q.tx_valid     <= p1_q.tx_valid;
      o_q.frame_end    <= p1_q.frame_end;
      o_q.accepted     <= p1_q.accepted;
      o_q.retransmit   <= p1_q.retransmit;
      o_q.phase        <= p1_q.phase;
      o_q.block_number <= p1_q.block_number;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_req_o   = o_q;

endmodule

FILE: sim/tb_xmodem_checksum_sender.sv
// Testbench for the XMODEM checksum sender: directed table, protocol-aware random, self-check.
`timescale 1ns / 100ps

module tb_xmodem_checksum_sender;
  import xmcs_pkg::*;

  localparam int unsigned HdrBytes    = 3;
  localparam int unsigned IdxW        = $clog2(PayloadBytes);
  localparam int unsigned RandomItems = 980;
  localparam int unsigned TailItems   = 8;
  localparam int unsigned LongHold    = 150;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned CycleLimit  = 600000;
  localparam logic [CfgAddrW-1:0] PadAddr = '0;

  typedef enum logic [1:0] {
    EndClean,
    EndBadBlockReply,
    EndBadEotReply
  } ending_e;

  typedef struct packed {
    in_req_t  req;
    out_req_t want;
  } dir_row_t;

  localparam out_req_t IdleLoad = '{tx_byte: 8'h00, tx_valid: 1'b0, frame_end: 1'b0,
    accepted: 1'b0, retransmit: 1'b0, phase: PhLoad, block_number: BlkReset};
  localparam out_req_t TakenLoad = '{tx_byte: 8'h00, tx_valid: 1'b0, frame_end: 1'b0,
    accepted: 1'b1, retransmit: 1'b0, phase: PhLoad, block_number: BlkReset};

  localparam int unsigned DirRows = 12;
  localparam dir_row_t DirTable [DirRows] = '{
    '{'{OpPull,  8'h00}, IdleLoad},
    '{'{OpPull,  8'hff}, IdleLoad},
    '{'{OpReply, ChAck}, IdleLoad},
    '{'{OpReply, ChNak}, IdleLoad},
    '{'{OpReply, 8'h00}, IdleLoad},
    '{'{OpReply, 8'hff}, IdleLoad},
    '{'{OpLoad,  8'h00}, TakenLoad},
    '{'{OpLoad,  8'hff}, TakenLoad},
    '{'{OpLoad,  8'h55}, TakenLoad},
    '{'{OpLoad,  8'haa}, TakenLoad},
    '{'{OpLoad,  8'h01}, TakenLoad},
    '{'{OpLoad,  8'h80}, TakenLoad}
  };

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready_o;
  in_req_t             in_req    = '0;
  logic                out_valid_o;
  logic                out_ready = 1'b0;
  out_req_t            out_req_o;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [CfgAddrW-1:0] paddr     = '0;
  logic [CfgDataW-1:0] pwdata    = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  // sender shadow state
  logic [7:0]  blk_mem [PayloadBytes];
  int unsigned fill_cnt  = 0;
  int unsigned send_pos  = 0;
  logic [7:0]  sum_acc   = 8'h00;
  logic [7:0]  blk_num   = BlkReset;
  phase_e      ph        = PhLoad;
  bit          eof_seen  = 1'b0;
  logic [7:0]  pad_val   = PadReset;

  out_req_t    pending_out_reqs [$];
  int unsigned mismatches  = 0;
  int unsigned cycle_cnt   = 0;
  bit          drain_hold  = 1'b0;
  bit          sender_calm = 1'b0;
  bit          finishing   = 1'b0;
  int unsigned tail_fill   = 0;
  ending_e     ending      = EndClean;

  xmodem_checksum_sender u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i  (in_valid),
    .in_ready_o,
    .in_req_i    (in_req),
    .out_valid_o,
    .out_ready_i (out_ready),
    .out_req_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int unsigned idle_gap();
    int unsigned roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void arm_frame();
    send_pos = 0;
    sum_acc  = 8'h00;
    ph       = PhSend;
  endfunction

  function automatic out_req_t advance_sender(in_req_t r);
    out_req_t o;
    o = '0;
    case (ph)
      PhLoad: begin
        if (r.opcode == OpLoad) begin
          o.accepted = 1'b1;
          if (fill_cnt < PayloadBytes) begin
            blk_mem[IdxW'(fill_cnt)] = r.data_byte;
            fill_cnt++;
          end
          if (fill_cnt >= PayloadBytes) arm_frame();
        end else if (r.opcode == OpEof) begin
          o.accepted = 1'b1;
          eof_seen   = 1'b1;
          if (fill_cnt > 0) arm_frame();
          else ph = PhEotP;
        end
      end
      PhSend: begin
        if (r.opcode == OpPull) begin
          o.tx_valid = 1'b1;
          if (send_pos == 0) begin
            o.tx_byte = ChSoh;
          end else if (send_pos == 1) begin
            o.tx_byte = blk_num;
          end else if (send_pos == 2) begin
            o.tx_byte = 8'hff - blk_num;
          end else if (send_pos < HdrBytes + PayloadBytes) begin
            o.tx_byte = (send_pos - HdrBytes < fill_cnt) ?
                        blk_mem[IdxW'(send_pos - HdrBytes)] : pad_val;
            sum_acc = sum_acc + o.tx_byte;
          end else begin
            o.tx_byte   = sum_acc;
            o.frame_end = 1'b1;
            ph          = PhWait;
          end
          send_pos++;
        end
      end
      PhWait: begin
        if (r.opcode == OpReply) begin
          if (r.data_byte == ChAck) begin
            blk_num  = blk_num + 8'd1;
            fill_cnt = 0;
            ph       = eof_seen ? PhEotP : PhLoad;
          end else if (r.data_byte == ChNak) begin
            o.retransmit = 1'b1;
            arm_frame();
          end else begin
            ph = PhErr;
          end
        end
      end
      PhEotP: begin
        if (r.opcode == OpPull) begin
          o.tx_valid  = 1'b1;
          o.tx_byte   = ChEot;
          o.frame_end = 1'b1;
          ph          = PhEotW;
        end
      end
      PhEotW: begin
        if (r.opcode == OpReply) ph = (r.data_byte == ChAck) ? PhDone : PhErr;
      end
      default: ;
    endcase
    o.phase        = ph;
    o.block_number = blk_num;
    return o;
  endfunction

  // mostly well-formed protocol traffic, one in ten harmless noise
  function automatic in_req_t pick_req();
    in_req_t    r;
    logic [1:0] main_op;
    r.data_byte = 8'($urandom);
    case (ph)
      PhLoad:         main_op = (finishing && fill_cnt >= tail_fill) ? OpEof : OpLoad;
      PhSend, PhEotP: main_op = OpPull;
      PhWait, PhEotW: main_op = OpReply;
      default:        main_op = 2'($urandom_range(0, 3));
    endcase
    r.opcode = main_op;
    if (ph == PhDone || ph == PhErr) return r;
    if ($urandom_range(0, 9) == 0) begin
      do r.opcode = 2'($urandom_range(0, 3));
      while (r.opcode == main_op || (ph == PhLoad && r.opcode == OpEof));
    end else if (ph == PhWait) begin
      if (ending == EndBadBlockReply && eof_seen) begin
        do r.data_byte = 8'($urandom);
        while (r.data_byte == ChAck || r.data_byte == ChNak);
      end else begin
        r.data_byte = ($urandom_range(0, 4) == 0) ? ChNak : ChAck;
      end
    end else if (ph == PhEotW) begin
      if (ending == EndBadEotReply) begin
        do r.data_byte = 8'($urandom);
        while (r.data_byte == ChAck);
      end else begin
        r.data_byte = ChAck;
      end
    end
    return r;
  endfunction

  function automatic void cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic push_req(input in_req_t r, input bit typed, input out_req_t typed_want);
    out_req_t    pred;
    int unsigned gap;
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    pred = advance_sender(r);
    pending_out_reqs.push_back(typed ? typed_want : pred);
    if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
    gap = sender_calm ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic apb_xfer(input bit wr, input logic [7:0] val, output logic [CfgDataW-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PadAddr;
    pwdata  <= CfgDataW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_pad();
    logic [CfgDataW-1:0] rd;
    apb_xfer(1'b0, 8'h00, rd);
    if (rd !== CfgDataW'(pad_val)) begin
      $error("pad_byte readback: expected %0h, got %0h", pad_val, rd);
      mismatches++;
    end
  endtask

  task automatic set_pad(input logic [7:0] v);
    logic [CfgDataW-1:0] rd;
    apb_xfer(1'b1, v, rd);
    pad_val = v;
    check_pad();
  endtask

  // receiver: random backpressure, quiet stretches, and long holds that fill the block
  initial begin
    int unsigned n;
    bit          rx_calm;
    rx_calm = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (drain_hold || $urandom_range(0, 299) == 0) begin
        drain_hold = 1'b0;
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end
      n = rx_calm ? 0 : idle_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
    end
  end

  always @(posedge clk_i) begin : out_check
    out_req_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_out_reqs.size() == 0) begin
        $error("output request with none pending: %p", out_req_o);
        mismatches++;
      end else begin
        want = pending_out_reqs.pop_front();
        cmp_field("tx_byte", want.tx_byte, out_req_o.tx_byte);
        cmp_field("tx_valid", 8'(want.tx_valid), 8'(out_req_o.tx_valid));
        cmp_field("frame_end", 8'(want.frame_end), 8'(out_req_o.frame_end));
        cmp_field("accepted", 8'(want.accepted), 8'(out_req_o.accepted));
        cmp_field("retransmit", 8'(want.retransmit), 8'(out_req_o.retransmit));
        cmp_field("phase", 8'(want.phase), 8'(out_req_o.phase));
        cmp_field("block_number", want.block_number, out_req_o.block_number);
      end
    end
  end

  initial begin
    int unsigned issued;
    int unsigned pad_writes;
    logic [7:0]  prev_blk;
    issued     = 0;
    pad_writes = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    check_pad();
    set_pad(8'($urandom));

    for (int i = 0; i < DirRows; i++) push_req(DirTable[i].req, 1'b1, DirTable[i].want);

    drain_hold = 1'b1;
    while (ph != PhDone && ph != PhErr) begin
      if (issued >= RandomItems && !finishing) begin
        finishing = 1'b1;
        ending    = ending_e'($urandom_range(0, 2));
        tail_fill = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, PayloadBytes - 1);
      end
      prev_blk = blk_num;
      push_req(pick_req(), 1'b0, '0);
      issued++;
      // block acked: go quiet, let the pipe empty, then retune the pad byte
      if (blk_num != prev_blk && ph == PhLoad) begin
        in_valid <= 1'b0;
        while (pending_out_reqs.size() != 0) @(posedge clk_i);
        case (pad_writes)
          0:       set_pad(8'h00);
          1:       set_pad(8'hff);
          default: begin
            case ($urandom_range(0, 2))
              0:       set_pad(8'h00);
              1:       set_pad(8'hff);
              default: set_pad(8'($urandom));
            endcase
          end
        endcase
        pad_writes++;
      end
    end

    repeat (TailItems) push_req(pick_req(), 1'b0, '0);
    in_valid <= 1'b0;

    while (pending_out_reqs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_out_reqs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
